// ===== src/smf_pkg.sv =====
// Shared types for the sliding median filter.
package smf_pkg;

  localparam int SAMPLE_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Payload of one input transaction.
  typedef struct packed {
    sample_t sample;
  } in_item_t;

  // Payload of one output transaction.
  typedef struct packed {
    sample_t median;
  } out_item_t;

  // Controls from the sequencer to the sample lines.
  typedef struct packed {
    logic load;    // shift a new sample into the arrival line
    logic rotate;  // advance the sorted line by one entry
  } line_ctl_t;

  // Result of the shared compare unit.
  typedef struct packed {
    logic lt;  // a < b, signed
    logic eq;  // a == b
  } cmp_res_t;

endpackage

// ===== src/smf_chan_if.sv =====
// Valid/ready channel carrying one payload per transaction.
interface smf_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/sliding_median_filter_unit.sv =====
// Top level of the sliding-window median filter.
// Keeps the last WINDOW signed 16-bit samples (zero after reset) and returns, for
// each sample, the median of the window including it; for an even WINDOW the lower
// middle value. A sample is taken only while the block is idle. After acceptance
// come the setup states ORDER and PREP, then a pass over the sorted copy, entry by
// entry, while the single shared comparator merges the new sample in and the
// departing one out, then the load of the output register. The next sample can be
// taken in the cycle after that, so a new sample is not taken before the last one
// is through; a result left waiting holds the block until it is taken.
module sliding_median_filter_unit #(
  parameter int WINDOW = 21
) (
  input  logic       clk,
  input  logic       rst,
  smf_chan_if.sink   sample_ch,
  smf_chan_if.source median_ch
);
  import smf_pkg::*;

  line_ctl_t line_ctl;
  cmp_res_t  cmp_res;
  sample_t   oldest_val;
  sample_t   head;
  sample_t   nxt;
  sample_t   emit_val;
  sample_t   cmp_a;
  sample_t   cmp_b;
  sample_t   median;

  // Sample storage.
  smf_lines #(.WINDOW(WINDOW)) u_lines (
    .clk        (clk),
    .rst        (rst),
    .ctl        (line_ctl),
    .sample     (sample_ch.payload.sample),
    .emit_val   (emit_val),
    .oldest_val (oldest_val),
    .head       (head),
    .nxt        (nxt)
  );

  // Shared comparator.
  smf_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  // Sequencer and output register.
  smf_ctrl #(.WINDOW(WINDOW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sample_ch.valid),
    .in_ready   (sample_ch.ready),
    .in_sample  (sample_ch.payload.sample),
    .out_valid  (median_ch.valid),
    .out_ready  (median_ch.ready),
    .out_median (median),
    .oldest_val (oldest_val),
    .head       (head),
    .nxt        (nxt),
    .line_ctl   (line_ctl),
    .emit_val   (emit_val),
    .cmp_a      (cmp_a),
    .cmp_b      (cmp_b),
    .cmp_res    (cmp_res)
  );

  assign median_ch.payload.median = median;
endmodule

// ===== src/smf_cmp.sv =====
// Shared signed compare unit used by the sequencer in its setup and merge states.
module smf_cmp (
  input  smf_pkg::sample_t  a,
  input  smf_pkg::sample_t  b,
  output smf_pkg::cmp_res_t res
);
  import smf_pkg::*;

  // One signed magnitude compare and one equality check.
  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end
endmodule

// ===== src/smf_lines.sv =====
// Arrival-order sample line and the rotating sorted copy of the window.
module smf_lines #(
  parameter int WINDOW = 21
) (
  input  logic                clk,
  input  logic                rst,
  input  smf_pkg::line_ctl_t  ctl,
  input  smf_pkg::sample_t    sample,
  input  smf_pkg::sample_t    emit_val,
  output smf_pkg::sample_t    oldest_val,
  output smf_pkg::sample_t    head,
  output smf_pkg::sample_t    nxt
);
  import smf_pkg::*;

  sample_t arrival [WINDOW];
  sample_t sorted  [WINDOW];

  // Arrival line: the newest sample enters at the front, the oldest drops off the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) arrival[k] <= '0;
    end else if (ctl.load) begin
      arrival[0] <= sample;
      for (int k = 1; k < WINDOW; k++) arrival[k] <= arrival[k-1];
    end
  end

  // Sorted line: each work cycle the head leaves and the merged value enters the tail.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) sorted[k] <= '0;
    end else if (ctl.rotate) begin
      for (int k = 0; k < WINDOW - 1; k++) sorted[k] <= sorted[k+1];
      sorted[WINDOW-1] <= emit_val;
    end
  end

  assign oldest_val = arrival[WINDOW-1];
  assign head       = sorted[0];
  assign nxt        = sorted[1];
endmodule

// ===== src/smf_ctrl.sv =====
// Sequencer: merges one removal and one insertion into the sorted line per sample.
module smf_ctrl #(
  parameter int WINDOW = 21
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  smf_pkg::sample_t    in_sample,
  output logic                out_valid,
  input  logic                out_ready,
  output smf_pkg::sample_t    out_median,
  input  smf_pkg::sample_t    oldest_val,
  input  smf_pkg::sample_t    head,
  input  smf_pkg::sample_t    nxt,
  output smf_pkg::line_ctl_t  line_ctl,
  output smf_pkg::sample_t    emit_val,
  output smf_pkg::sample_t    cmp_a,
  output smf_pkg::sample_t    cmp_b,
  input  smf_pkg::cmp_res_t   cmp_res
);
  import smf_pkg::*;

  localparam int IW  = $clog2(WINDOW);
  localparam int MID = (WINDOW - 1) / 2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ORDER = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_SHIFT = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t        state, state_next;
  logic [IW-1:0] idx;
  logic          last;
  logic          accept;
  logic          rotating;
  logic          carry_load;
  logic          out_load;
  logic          below;      // new sample is below the departing one
  sample_t       fresh;      // sample being inserted
  sample_t       old_val;    // sample being removed
  sample_t       carry;      // entry held back while larger entries move up
  sample_t       med;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign last     = (idx == IW'(WINDOW - 1));
  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  assign line_ctl.load   = accept;
  assign line_ctl.rotate = rotating;

  // Merge decisions. Each work cycle writes exactly one entry to the sorted tail.
  // When the new sample is not below the old one, entries between them move down
  // one place; otherwise they move up one place through the carry register.
  always_comb begin
    state_next = state;
    emit_val   = head;
    carry_load = 1'b0;
    rotating   = 1'b0;
    cmp_a      = head;
    cmp_b      = fresh;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_ORDER;
      end
      S_ORDER: begin
        cmp_a      = fresh;
        cmp_b      = old_val;
        state_next = S_PREP;
      end
      S_PREP: begin
        // The removed entry may sit at the very front of the sorted line.
        cmp_a = head;
        cmp_b = old_val;
        if (!below && cmp_res.eq) state_next = S_SHIFT;
        else                      state_next = S_SCAN;
      end
      S_SCAN: begin
        rotating = 1'b1;
        if (below) begin
          cmp_a = head;
          cmp_b = fresh;
          if (!cmp_res.lt && !cmp_res.eq) begin
            emit_val   = fresh;
            carry_load = 1'b1;
            state_next = S_SHIFT;
          end
        end else begin
          // Look one entry ahead for the one to remove.
          cmp_a = nxt;
          cmp_b = old_val;
          if (cmp_res.eq && !last) state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        rotating = 1'b1;
        if (below) begin
          cmp_a = carry;
          cmp_b = old_val;
          if (cmp_res.eq) begin
            emit_val   = head;
            state_next = S_DONE;
          end else begin
            emit_val   = carry;
            carry_load = 1'b1;
          end
        end else begin
          cmp_a = nxt;
          cmp_b = fresh;
          if (cmp_res.lt && !last) begin
            emit_val = nxt;
          end else begin
            emit_val   = fresh;
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        rotating = 1'b1;
      end
      S_EMIT: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (rotating && last) state_next = S_EMIT;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Position counter along the sorted line.
  always_ff @(posedge clk) begin
    if (state == S_PREP) idx <= '0;
    else if (rotating)   idx <= idx + 1'b1;
  end

  // Operands and direction of the current merge.
  always_ff @(posedge clk) begin
    if (accept) begin
      fresh   <= in_sample;
      old_val <= oldest_val;
    end
    if (state == S_ORDER) below <= cmp_res.lt;
    if (carry_load)       carry <= head;
    if (rotating && (idx == IW'(MID))) med <= emit_val;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (out_load)  out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) out_median <= med;
  end
endmodule

// ===== src/smf_checker.sv =====
// Port-level checks for the sliding median filter, bound to the top level.
module smf_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input smf_pkg::sample_t median
);
  import smf_pkg::*;

  // The block stays busy for at least the setup cycles after taking a sample.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input ready returned too soon after a transaction");

  // A result never appears in the cycle right after a sample is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result produced without any work cycles");

  // A pending result stays until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output transaction dropped before it was taken");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(median))
    else $error("stalled median changed");
endmodule

bind sliding_median_filter_unit smf_checker u_smf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_ch.valid),
  .in_ready  (sample_ch.ready),
  .out_valid (median_ch.valid),
  .out_ready (median_ch.ready),
  .median    (median_ch.payload.median)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sliding-window median filter unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import smf_pkg::*;

  localparam int WINDOW      = 21;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 3 * (WINDOW + 3);
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 300;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_SPARSE
  } stall_mode_e;

  typedef enum int {
    RUN_FULL,
    RUN_TIES,
    RUN_EXTREME,
    RUN_RAMP,
    RUN_NEAR_EDGE
  } run_kind_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Testbench-side drivers of the channel inputs, known from time zero.
  logic     snd_valid   = 1'b0;
  in_item_t snd_payload = '0;
  logic     rcv_ready   = 1'b0;

  smf_chan_if #(.T(in_item_t))  sample_ch ();
  smf_chan_if #(.T(out_item_t)) median_ch ();

  assign sample_ch.valid   = snd_valid;
  assign sample_ch.payload = snd_payload;
  assign median_ch.ready   = rcv_ready;

  sliding_median_filter_unit #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .sample_ch(sample_ch),
    .median_ch(median_ch)
  );

  // Predictor state: the last WINDOW samples in a ring and the slot the next one replaces.
  sample_t window_hist [WINDOW];
  int      next_slot;

  sample_t pending_samples [$];
  sample_t expected_medians [$];

  int          mismatch_count = 0;
  int          results_seen   = 0;
  int          cycle_count    = 0;
  logic        in_fire        = 1'b0;
  int          burst_left     = 0;
  int          gap_left       = 0;
  int          hold_left      = 0;
  logic        hold_done      = 1'b0;
  int          rcv_cycle      = 0;
  stall_mode_e stall_mode     = READY_ALWAYS;

  // Replace the oldest sample and return the lower-middle value of the sorted window.
  function automatic sample_t median_after(input sample_t s);
    sample_t ranked [WINDOW];
    sample_t tmp;
    int      i;
    int      j;
    window_hist[next_slot] = s;
    next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
    for (i = 0; i < WINDOW; i++) ranked[i] = window_hist[i];
    for (i = 1; i < WINDOW; i++) begin
      tmp = ranked[i];
      j = i - 1;
      while (j >= 0 && ranked[j] > tmp) begin
        ranked[j + 1] = ranked[j];
        j--;
      end
      ranked[j + 1] = tmp;
    end
    return ranked[(WINDOW - 1) / 2];
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  // Synchronous reset held from time zero, released on a falling edge.
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Sample both channels at the rising edge: predict on input, check on output.
  always @(posedge clk) begin
    sample_t exp_median;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      in_fire = !rst && sample_ch.valid && sample_ch.ready;
      if (in_fire) expected_medians.push_back(median_after(sample_ch.payload.sample));
      if (!rst && median_ch.valid && median_ch.ready) begin
        results_seen++;
        if (expected_medians.size() == 0) begin
          mismatch_count++;
          $display("%0t: median expected none got %0d", $time, median_ch.payload.median);
        end else begin
          exp_median = expected_medians.pop_front();
          if (median_ch.payload.median !== exp_median) begin
            mismatch_count++;
            $display("%0t: median expected %0d got %0d", $time, exp_median,
                     median_ch.payload.median);
          end
        end
      end
    end
  end

  // Sender: bursts of transactions separated by random gaps, valid held until taken.
  always @(negedge clk) begin
    if (rst) begin
      snd_valid <= 1'b0;
    end else if (snd_valid && !in_fire) begin
      snd_valid <= 1'b1;
    end else begin
      if (snd_valid && in_fire) begin
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          burst_left = $urandom_range(1, 12);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        snd_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        snd_payload.sample <= pending_samples.pop_front();
        snd_valid <= 1'b1;
      end else begin
        snd_valid <= 1'b0;
      end
    end
  end

  // Receiver: switches among stall patterns and once holds off for a long stretch.
  always @(negedge clk) begin
    rcv_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      rcv_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rcv_ready <= 1'b0;
    end else begin
      case (stall_mode)
        READY_ALWAYS:   rcv_ready <= 1'b1;
        READY_RANDOM:   rcv_ready <= 1'($urandom_range(0, 1));
        READY_PERIODIC: rcv_ready <= (rcv_cycle % 7) >= 3;
        default:        rcv_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
    if (rcv_cycle % 300 == 0) stall_mode = stall_mode_e'($urandom_range(0, 3));
  end

  // Stimulus and end of run.
  initial begin
    sample_t   v;
    run_kind_e kind;
    int        run_len;
    int        n;
    int        k;

    for (k = 0; k < WINDOW; k++) window_hist[k] = '0;
    next_slot = 0;

    // Directed part: extremes while zeros from reset still fill the window,
    // alternating bit patterns, then a run of equal values.
    pending_samples.push_back(16'sh7FFF);
    pending_samples.push_back(16'sh7FFF);
    pending_samples.push_back(16'sh7FFF);
    pending_samples.push_back(-16'sh8000);
    pending_samples.push_back(-16'sh8000);
    pending_samples.push_back(-16'sh8000);
    pending_samples.push_back(16'sh0000);
    pending_samples.push_back(-16'sh0001);
    pending_samples.push_back(16'sh0001);
    pending_samples.push_back(16'sh5555);
    pending_samples.push_back(sample_t'(16'hAAAA));
    for (k = 0; k < 12; k++) pending_samples.push_back(16'sh0007);

    // Random part in runs of different character.
    n = 0;
    v = '0;
    while (n < RANDOM_ITEMS) begin
      kind    = run_kind_e'($urandom_range(0, 4));
      run_len = $urandom_range(5, 40);
      for (k = 0; k < run_len && n < RANDOM_ITEMS; k++) begin
        case (kind)
          RUN_FULL:    v = sample_t'($urandom);
          RUN_TIES:    v = sample_t'(int'($urandom_range(0, 6)) - 3);
          RUN_EXTREME: begin
            case ($urandom_range(0, 3))
              0:       v = 16'sh7FFF;
              1:       v = -16'sh8000;
              2:       v = -16'sh0001;
              default: v = 16'sh0000;
            endcase
          end
          RUN_RAMP:    v = v + sample_t'(int'($urandom_range(0, 200)) - 100);
          default:     v = ($urandom_range(0, 1) == 0) ?
                           sample_t'(32767 - int'($urandom_range(0, 3))) :
                           sample_t'(-32768 + int'($urandom_range(0, 3)));
        endcase
        pending_samples.push_back(v);
        n++;
      end
    end

    // Wait for every sample to be taken and every median to arrive.
    @(posedge clk);
    while (pending_samples.size() > 0 || snd_valid) @(posedge clk);
    while (expected_medians.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0 && expected_medians.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
